// ===== design/kvpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvpc_pkg
// Shared codes and controller/datapath interface types for the record cache.
// ----------------------------------------------------------------------------
package kvpc_pkg;

    localparam int TAG_W   = 24;
    localparam int STAMP_W = 63;
    localparam int OUT_VAL_W = 32;

    // request kinds (s_tuser)
    localparam logic [2:0] MODE_SELECT  = 3'd0;
    localparam logic [2:0] MODE_INSERT  = 3'd1;
    localparam logic [2:0] MODE_FILL    = 3'd2;
    localparam logic [2:0] MODE_JOURNAL = 3'd3;
    localparam logic [2:0] MODE_DROP    = 3'd4;

    // result kinds (m_tuser)
    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_STORED = 3'd1;
    localparam logic [2:0] ST_MISS   = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic       req_load;
        logic       search;
        logic       rd_hit;
        logic       rd_scan;
        logic       touch_hit;
        logic       place_free;
        logic       place_victim;
        logic       stamp_upd;
        logic       release_scan;
        logic       clear_all;
        logic       scan_clr;
        logic       scan_inc;
        logic       out_load;
        logic       out_data;
        logic [2:0] out_status;
        logic       out_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] mode;
        logic       hit;
        logic       free_found;
        logic       scan_match;
        logic       scan_dirty;
        logic       scan_end_used;
        logic       scan_end_all;
    } sts_t;

endpackage
`default_nettype wire

// ===== design/kvpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvpc_datapath
// Tag match lanes, recency ranks, used/dirty bits, record memory, scan
// counter and the result register.
// ----------------------------------------------------------------------------
module kvpc_datapath
    import kvpc_pkg::*;
#(
    parameter int FRAMES     = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [2:0]           in_mode,
    input  wire logic [7:0]           in_table,
    input  wire logic [15:0]          in_key,
    input  wire logic [31:0]          in_value,
    input  wire logic [STAMP_W-1:0]   in_stamp,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic [2:0]                out_status,
    output logic                      out_last,
    output logic [7:0]                out_table,
    output logic [15:0]               out_key,
    output logic [OUT_VAL_W-1:0]      out_value,
    output logic [STAMP_W-1:0]        out_stamp
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int MW = STAMP_W + VALUE_BITS;

    // request registers
    logic [2:0]            mode_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [STAMP_W-1:0]    stamp_reg;

    // frame state
    logic [FRAMES-1:0] used_reg;
    logic [FRAMES-1:0] dirty_reg;
    logic [TAG_W-1:0]  ftag_reg [FRAMES];
    logic [IW-1:0]     rank_reg [FRAMES];
    logic [CW-1:0]     used_cnt_reg;

    // search and scan results
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [CW-1:0] scan_cnt_reg;

    // record memory: {stamp, value}
    logic [MW-1:0] mem [FRAMES];
    logic [MW-1:0] rd_data_reg;

    logic [FRAMES-1:0] hit_vec;
    logic [FRAMES-1:0] scan_vec;
    logic          hit_any;
    logic [IW-1:0] hit_idx;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] scan_rank;
    logic [IW-1:0] drop_idx;
    logic          drop_hit;
    logic          touch_en;
    logic [IW-1:0] tgt_idx;
    logic [IW-1:0] ref_rank;
    logic          dec_en;
    logic          stamp_ge;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic          new_dirty;

    assign scan_rank = scan_cnt_reg[IW-1:0];
    assign drop_idx  = scan_cnt_reg[IW-1:0];

    // match lanes and encoders
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        scan_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            hit_vec[i]  = used_reg[i] && (ftag_reg[i] == tag_reg);
            scan_vec[i] = used_reg[i] && (rank_reg[i] == scan_rank);
        end
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!used_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
            if (scan_vec[i]) begin
                scan_idx = IW'(i);
            end
        end
    end

    assign drop_hit  = used_reg[drop_idx] && (ftag_reg[drop_idx][23:16] == tag_reg[23:16]);
    assign touch_en  = cmd.touch_hit || cmd.place_victim;
    assign tgt_idx   = cmd.touch_hit ? hit_idx_reg : scan_idx;
    assign stamp_ge  = stamp_reg >= rd_data_reg[MW-1:VALUE_BITS];
    assign new_dirty = (mode_reg == MODE_INSERT);
    assign dec_en    = touch_en || (cmd.release_scan && drop_hit);

    always_comb begin
        priority if (cmd.touch_hit) begin
            ref_rank = rank_reg[hit_idx_reg];
        end else if (cmd.place_victim) begin
            ref_rank = scan_rank;
        end else begin
            ref_rank = rank_reg[drop_idx];
        end
    end

    // status to controller
    assign sts.mode          = mode_reg;
    assign sts.hit           = hit_reg;
    assign sts.free_found    = free_found_reg;
    assign sts.scan_match    = |scan_vec;
    assign sts.scan_dirty    = |(scan_vec & dirty_reg);
    assign sts.scan_end_used = scan_cnt_reg >= used_cnt_reg;
    assign sts.scan_end_all  = scan_cnt_reg == CW'(FRAMES - 1);

    // request capture, search and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            mode_reg  <= in_mode;
            tag_reg   <= {in_table, in_key};
            val_reg   <= VALUE_BITS'(in_value);
            stamp_reg <= in_stamp;
        end
        if (cmd.search) begin
            hit_reg        <= hit_any;
            hit_idx_reg    <= hit_idx;
            free_found_reg <= free_any;
            free_idx_reg   <= free_idx;
        end
        if (cmd.scan_clr) begin
            scan_cnt_reg <= '0;
        end else if (cmd.scan_inc) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    // frame state: ranks, tags, used and dirty bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            dirty_reg    <= '0;
            used_cnt_reg <= '0;
        end else if (cmd.clear_all) begin
            used_reg     <= '0;
            dirty_reg    <= '0;
            used_cnt_reg <= '0;
        end else begin
            if (dec_en) begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (used_reg[i] && (rank_reg[i] > ref_rank)) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
            end
            if (touch_en) begin
                rank_reg[tgt_idx] <= IW'(used_cnt_reg - 1'b1);
            end
            if (cmd.place_victim) begin
                ftag_reg[scan_idx]  <= tag_reg;
                dirty_reg[scan_idx] <= new_dirty;
            end
            if (cmd.stamp_upd && stamp_ge) begin
                dirty_reg[hit_idx_reg] <= 1'b1;
            end
            if (cmd.place_free) begin
                rank_reg[free_idx_reg]  <= IW'(used_cnt_reg);
                used_reg[free_idx_reg]  <= 1'b1;
                ftag_reg[free_idx_reg]  <= tag_reg;
                dirty_reg[free_idx_reg] <= new_dirty;
                used_cnt_reg            <= used_cnt_reg + 1'b1;
            end
            if (cmd.release_scan && drop_hit) begin
                used_reg[drop_idx]  <= 1'b0;
                dirty_reg[drop_idx] <= 1'b0;
                used_cnt_reg        <= used_cnt_reg - 1'b1;
            end
        end
    end

    // record memory, one write and one registered read
    always_comb begin
        priority if (cmd.place_free) begin
            mem_we = 1'b1;
            mem_wa = free_idx_reg;
        end else if (cmd.place_victim) begin
            mem_we = 1'b1;
            mem_wa = scan_idx;
        end else if (cmd.stamp_upd && stamp_ge) begin
            mem_we = 1'b1;
            mem_wa = hit_idx_reg;
        end else begin
            mem_we = 1'b0;
            mem_wa = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= {stamp_reg, val_reg};
        end
        if (cmd.rd_hit) begin
            rd_data_reg <= mem[hit_idx_reg];
            rd_idx_reg  <= hit_idx_reg;
        end else if (cmd.rd_scan) begin
            rd_data_reg <= mem[scan_idx];
            rd_idx_reg  <= scan_idx;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status <= cmd.out_status;
            out_last   <= cmd.out_last;
            if (cmd.out_data) begin
                out_table <= ftag_reg[rd_idx_reg][23:16];
                out_key   <= ftag_reg[rd_idx_reg][15:0];
                out_value <= OUT_VAL_W'(rd_data_reg[VALUE_BITS-1:0]);
                out_stamp <= rd_data_reg[MW-1:VALUE_BITS];
            end else begin
                out_table <= '0;
                out_key   <= '0;
                out_value <= '0;
                out_stamp <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/kvpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvpc_ctrl
// Request sequencer: search, update, victim scan, journal and drop walks.
// ----------------------------------------------------------------------------
module kvpc_ctrl
    import kvpc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_RD, S_UPD, S_VSCAN,
        S_JSCAN, S_JRD, S_JOUT, S_DSCAN, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_JOUT);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.out_last = 1'b1;
                priority case (sts.mode)
                    MODE_SELECT: begin
                        if (sts.hit) begin
                            cmd.rd_hit    = 1'b1;
                            cmd.touch_hit = 1'b1;
                            state_next    = S_RD;
                        end else begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_MISS;
                            state_next     = S_OUT;
                        end
                    end
                    MODE_INSERT, MODE_FILL: begin
                        if (sts.hit && sts.mode == MODE_INSERT) begin
                            cmd.rd_hit = 1'b1;
                            state_next = S_UPD;
                        end else if (sts.hit) begin
                            cmd.touch_hit  = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_STORED;
                            state_next     = S_OUT;
                        end else if (sts.free_found) begin
                            cmd.place_free = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_STORED;
                            state_next     = S_OUT;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_VSCAN;
                        end
                    end
                    MODE_JOURNAL: begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_JSCAN;
                    end
                    MODE_DROP: begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_DSCAN;
                    end
                    default: begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_DONE;
                        state_next     = S_OUT;
                    end
                endcase
            end
            S_RD: begin
                cmd.out_load   = 1'b1;
                cmd.out_data   = 1'b1;
                cmd.out_status = ST_HIT;
                cmd.out_last   = 1'b1;
                state_next     = S_OUT;
            end
            S_UPD: begin
                cmd.stamp_upd  = 1'b1;
                cmd.touch_hit  = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_STORED;
                cmd.out_last   = 1'b1;
                state_next     = S_OUT;
            end
            // every frame is used here: walk ranks oldest first for a clean one
            S_VSCAN: begin
                cmd.out_last = 1'b1;
                if (sts.scan_match && !sts.scan_dirty) begin
                    cmd.place_victim = 1'b1;
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = ST_STORED;
                    state_next       = S_OUT;
                end else if (sts.scan_end_all) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_FULL;
                    state_next     = S_OUT;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_JSCAN: begin
                if (sts.scan_end_used) begin
                    cmd.clear_all  = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DONE;
                    cmd.out_last   = 1'b1;
                    state_next     = S_OUT;
                end else if (sts.scan_dirty) begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_JRD;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_JRD: begin
                cmd.out_load   = 1'b1;
                cmd.out_data   = 1'b1;
                cmd.out_status = ST_FLUSH;
                state_next     = S_JOUT;
            end
            S_JOUT: begin
                if (m_tready) begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_JSCAN;
                end
            end
            S_DSCAN: begin
                cmd.release_scan = 1'b1;
                if (sts.scan_end_all) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DONE;
                    cmd.out_last   = 1'b1;
                    state_next     = S_OUT;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/key_value_page_cache_lru_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_page_cache_lru_unit
// Write-back record cache with LRU replacement of clean entries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (s_tuser = mode), results leave on the
//   m_ channel (m_tuser = status, m_tlast on the final beat of a request).
//   One request is in flight at a time; s_tready is high only while idle.
//   Steps per request, up to the result beat:
//     select, fill, insert hit or miss into a free frame: search, decide
//       and, where a hit needs one, a record read or a stamp update.
//     insert/fill into a full cache: also the rank walk that looks for the
//       least recent clean frame.
//     journal: a walk over the used ranks, one flush beat per dirty frame.
//     drop: one frame checked per cycle, released if it holds the table.
//   Beats that return a stored record wait for the memory's registered read.
//   Reset empties the cache at once (used and dirty bits are flops); no
//   clearing pass. A stalled m_tready holds the result beat and the
//   sequencer; nothing is dropped.
// ----------------------------------------------------------------------------
module key_value_page_cache_lru_unit
    import kvpc_pkg::*;
#(
    parameter int FRAMES     = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,  // table[7:0], key[23:8], value[55:24], stamp[118:56]
    input  wire logic [2:0]   s_tuser,  // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,  // table[7:0], key[23:8], value[55:24], stamp[118:56]
    output logic [2:0]        m_tuser,  // status
    output logic              m_tlast
);

    cmd_t cmd;
    sts_t sts;

    logic [7:0]           o_table;
    logic [15:0]          o_key;
    logic [OUT_VAL_W-1:0] o_value;
    logic [STAMP_W-1:0]   o_stamp;

    kvpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kvpc_datapath #(
        .FRAMES     (FRAMES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_mode    (s_tuser),
        .in_table   (s_tdata[7:0]),
        .in_key     (s_tdata[23:8]),
        .in_value   (s_tdata[55:24]),
        .in_stamp   (s_tdata[118:56]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_tuser),
        .out_last   (m_tlast),
        .out_table  (o_table),
        .out_key    (o_key),
        .out_value  (o_value),
        .out_stamp  (o_stamp)
    );

    assign m_tdata = {1'b0, o_stamp, o_value, o_key, o_table};

endmodule
`default_nettype wire

// ===== design/kvpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvpc_checker
// Port-level checks on the record cache, bound to the top level.
// ----------------------------------------------------------------------------
module kvpc_checker
    import kvpc_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [119:0] m_tdata,
    input wire logic [2:0]   m_tuser,
    input wire logic         m_tlast
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // one request at a time: no intake while a result is pending
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("intake open while result pending");

    // an accepted request closes the intake
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("intake still open after a request beat");

    // only journal flush beats are non-final
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == ST_FLUSH)
        else $error("non-final beat that is not a flush");

    // miss, full and done beats carry no record
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_MISS || m_tuser == ST_FULL || m_tuser == ST_DONE)
        |-> m_tdata == '0)
        else $error("status without record carries data");

endmodule

bind key_value_page_cache_lru_unit kvpc_checker u_kvpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
